### rtl/smtd_pkg.sv
package smtd_pkg;

  // sample and delay formats
  localparam int SAMPLE_W = 24;
  localparam int DLY_W    = 18;
  localparam int CFG_W    = 54;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W   = 41;

  // q0.16 gains and rounding constant
  localparam logic [15:0] GAIN_STORE = 16'd58982;
  localparam logic [15:0] GAIN_DRY   = 16'd6554;
  localparam logic [15:0] ROUND_HALF = 16'd32768;

  localparam logic signed [SAMPLE_W+1:0] SAT_MAX = 26'sd8388607;
  localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -26'sd8388608;

  // register indexes of the write port
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_C = 3'd5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [DLY_W-1:0] delay_t;

  // per-request sequencing strobes from the sequencer to each lane
  typedef struct packed {
    logic load;
    logic write;
    logic issue;
    logic mul;
    logic fix;
    logic sum;
  } lane_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_ISSUE,
    S_DRAIN1,
    S_DRAIN2,
    S_MUL,
    S_FIX,
    S_SUM,
    S_DONE
  } seq_state_t;

endpackage

### rtl/smtd_in_if.sv
interface smtd_in_if import smtd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

### rtl/smtd_out_if.sv
interface smtd_out_if import smtd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

### rtl/smtd_lane.sv
module smtd_lane import smtd_pkg::*; #(
  parameter int TAPS        = 8,
  parameter int STORE_DEPTH = 262144
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lane_ctrl_t                    ctrl,
  input  logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] tap_sel,
  input  logic [TAPS-1:0][DLY_W-1:0]    delays,
  input  logic [$clog2(STORE_DEPTH)-1:0] wp,
  input  logic [$clog2(STORE_DEPTH):0]   fill,
  input  sample_t                       sample,
  output sample_t                       result
);

  localparam int AW        = $clog2(STORE_DEPTH);
  localparam int FLOOR_LOG = $clog2(STORE_DEPTH + 1) - 1;
  localparam int RED_STEPS = (DLY_W > FLOOR_LOG) ? DLY_W - FLOOR_LOG : 0;
  localparam int RW        = DLY_W + 1;
  localparam int ACC_W     = SAMPLE_W + $clog2(TAPS);
  localparam int UN_W      = ACC_W + 5;
  localparam int D2        = 2 * TAPS;
  localparam int AVG_W     = SAMPLE_W + 1;
  localparam logic [UN_W-1:0] BIAS     = UN_W'(D2) << ACC_W;
  localparam logic [UN_W-1:0] ACC_INIT = BIAS + UN_W'(TAPS);
  localparam logic [UN_W-1:0] RECIP    = UN_W'((65'(1) << UN_W) / D2);
  localparam logic [UN_W-1:0] UNBIAS   = UN_W'(1) << ACC_W;

  sample_t x;
  sample_t dry;
  sample_t mem [STORE_DEPTH];
  sample_t rd_data;

  logic signed [PROD_W-1:0] store_prod;
  logic signed [PROD_W-1:0] dry_prod;
  sample_t store_val;
  sample_t dry_val;

  logic [RW-1:0]   rem;
  logic [AW-1:0]   tap_off;
  logic [AW-1:0]   addr_next;
  logic [AW-1:0]   addr_q;
  logic            issue_q;
  logic            read_q;
  logic            hit_q;

  logic [UN_W-1:0]   acc;
  logic [2*UN_W-1:0] prod;
  logic [UN_W-1:0]   q_est;
  logic [UN_W-1:0]   div_rem;
  logic [UN_W-1:0]   avg_wide;
  logic signed [AVG_W-1:0] avg;
  logic signed [SAMPLE_W+1:0] total;

  // 0.9 and 0.1 gains, round half up
  assign store_prod = PROD_W'(x) * $signed({1'b0, GAIN_STORE}) + $signed({1'b0, ROUND_HALF});
  assign dry_prod   = PROD_W'(x) * $signed({1'b0, GAIN_DRY}) + $signed({1'b0, ROUND_HALF});
  assign store_val  = store_prod[16 +: SAMPLE_W];
  assign dry_val    = dry_prod[16 +: SAMPLE_W];

  // tap address: delay modulo depth, then behind the write pointer
  always_comb begin
    rem = RW'(delays[tap_sel]);
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (rem >= (RW'(STORE_DEPTH) << k)) begin
        rem = rem - (RW'(STORE_DEPTH) << k);
      end
    end
    tap_off = rem[AW-1:0];
    if (wp >= tap_off) begin
      addr_next = wp - tap_off;
    end else begin
      addr_next = AW'((AW+1)'(wp) + (AW+1)'(STORE_DEPTH) - (AW+1)'(tap_off));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= sample;
    end
    if (ctrl.write) begin
      mem[wp] <= store_val;
      dry     <= dry_val;
    end
    if (issue_q) begin
      rd_data <= mem[addr_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_q <= 1'b0;
      read_q  <= 1'b0;
    end else begin
      issue_q <= ctrl.issue;
      read_q  <= issue_q;
    end
  end

  // entries past the fill count read as zero
  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      addr_q <= addr_next;
    end
    if (issue_q) begin
      hit_q <= ({1'b0, addr_q} < fill);
    end
  end

  // biased running sum of 2 * taps, kept non-negative
  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      acc <= ACC_INIT;
    end else if (read_q && hit_q) begin
      acc <= acc + {{(UN_W-SAMPLE_W-1){rd_data[SAMPLE_W-1]}}, rd_data, 1'b0};
    end
  end

  // divide by 2 * taps: reciprocal, then one correction step
  assign q_est    = prod[2*UN_W-1 -: UN_W];
  assign div_rem  = acc - q_est * UN_W'(D2);
  assign avg_wide = q_est + UN_W'(div_rem >= UN_W'(D2)) - UNBIAS;
  assign total    = (SAMPLE_W+2)'(avg) + (SAMPLE_W+2)'(dry);

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= (2*UN_W)'(acc) * (2*UN_W)'(RECIP);
    end
    if (ctrl.fix) begin
      avg <= $signed(avg_wide[AVG_W-1:0]);
    end
    if (ctrl.sum) begin
      if (total > SAT_MAX) begin
        result <= SAT_MAX[SAMPLE_W-1:0];
      end else if (total < SAT_MIN) begin
        result <= SAT_MIN[SAMPLE_W-1:0];
      end else begin
        result <= total[SAMPLE_W-1:0];
      end
    end
  end

endmodule

### rtl/stereo_multitap_delay.sv
// channel   | dir | payload                        | handshake
// samples   | in  | left_in, right_in (q1.23)      | valid / ready
// results   | out | left_out, right_out (q1.23)    | valid / ready
// cfg       | in  | cfg_index, cfg_data (tap delays) | cfg_we, no back-pressure
//
// one sample pair at a time: the next is accepted only back in S_IDLE, a pace
// set by the one read port per channel store: taps are read one per cycle
// reset clears the write pointer, the fill count and the tap delay registers;
// the stores are not cleared, entries beyond the fill count read as zero
// a finished result waits in the output register while the next request is taken;
// the sequencer only holds in its last state if that register is still full
module stereo_multitap_delay import smtd_pkg::*; #(
  parameter int TAPS        = 8,
  parameter int STORE_DEPTH = 262144
) (
  input  logic                 clk,
  input  logic                 rst,
  smtd_in_if.sink              samples,
  smtd_out_if.source           results,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int TAP_CW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FLAT_W = 8 * DLY_W;

  // tap delay registers, tap 0 in the low bits
  logic [CFG_W-1:0] left_taps_a;
  logic [CFG_W-1:0] left_taps_b;
  logic [35:0]      left_taps_c;
  logic [CFG_W-1:0] right_taps_a;
  logic [CFG_W-1:0] right_taps_b;
  logic [35:0]      right_taps_c;

  logic [FLAT_W-1:0] left_flat;
  logic [FLAT_W-1:0] right_flat;
  logic [TAPS-1:0][DLY_W-1:0] left_dly;
  logic [TAPS-1:0][DLY_W-1:0] right_dly;

  seq_state_t state;
  seq_state_t state_next;
  lane_ctrl_t ctrl;

  logic [TAP_CW-1:0] tap_idx;
  logic              last_tap;
  logic [AW-1:0]     wp;
  logic [AW:0]       fill;

  logic    out_valid;
  logic    out_load;
  sample_t left_res;
  sample_t right_res;
  sample_t left_q;
  sample_t right_q;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      left_taps_a  <= '0;
      left_taps_b  <= '0;
      left_taps_c  <= '0;
      right_taps_a <= '0;
      right_taps_b <= '0;
      right_taps_c <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEFT_A:  left_taps_a  <= cfg_data;
        CFG_LEFT_B:  left_taps_b  <= cfg_data;
        CFG_LEFT_C:  left_taps_c  <= cfg_data[35:0];
        CFG_RIGHT_A: right_taps_a <= cfg_data;
        CFG_RIGHT_B: right_taps_b <= cfg_data;
        CFG_RIGHT_C: right_taps_c <= cfg_data[35:0];
        default: ;
      endcase
    end
  end

  // unpack the delay fields; taps at or beyond TAPS are dropped here
  assign left_flat  = {left_taps_c, left_taps_b, left_taps_a};
  assign right_flat = {right_taps_c, right_taps_b, right_taps_a};

  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      left_dly[t]  = left_flat[DLY_W*t +: DLY_W];
      right_dly[t] = right_flat[DLY_W*t +: DLY_W];
    end
  end

  // sequencer
  assign samples.ready = (state == S_IDLE);
  assign last_tap      = (tap_idx == TAP_CW'(TAPS - 1));
  assign out_load      = (state == S_DONE) && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        ctrl.load = samples.valid;
        if (samples.valid) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        // store the scaled sample before any tap is read
        ctrl.write = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        ctrl.issue = 1'b1;
        if (last_tap) begin
          state_next = S_DRAIN1;
        end
      end
      // memory read and last accumulate still in flight
      S_DRAIN1: state_next = S_DRAIN2;
      S_DRAIN2: state_next = S_MUL;
      S_MUL: begin
        ctrl.mul   = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        ctrl.fix   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        ctrl.sum   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // tap counter, write pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_idx <= '0;
      wp      <= '0;
      fill    <= '0;
    end else begin
      if (ctrl.issue) begin
        tap_idx <= last_tap ? '0 : tap_idx + 1'b1;
      end
      if (ctrl.write && (fill != (AW+1)'(STORE_DEPTH))) begin
        fill <= fill + 1'b1;
      end
      if (out_load) begin
        wp <= (wp == AW'(STORE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

  // one lane per channel, same sequencing
  smtd_lane #(
    .TAPS        (TAPS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_left (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .tap_sel (tap_idx),
    .delays  (left_dly),
    .wp      (wp),
    .fill    (fill),
    .sample  (samples.left_in),
    .result  (left_res)
  );

  smtd_lane #(
    .TAPS        (TAPS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_right (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .tap_sel (tap_idx),
    .delays  (right_dly),
    .wp      (wp),
    .fill    (fill),
    .sample  (samples.right_in),
    .result  (right_res)
  );

  // output register merges both lanes into one result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_q  <= left_res;
      right_q <= right_res;
    end
  end

  assign results.valid     = out_valid;
  assign results.left_out  = left_q;
  assign results.right_out = right_q;

endmodule
